@@ sv/ubd_pkg.sv @@
// Shared constants, widths and helpers of the baud divisor calculator.
package ubd_pkg;

	localparam int unsigned REF_CLOCK_HZ_DEF = 48000000;

	localparam int RATE_W  = 22;
	localparam int DIV1_W  = 9;
	localparam int DIVQ_W  = 9;
	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 16;
	localparam int STEP_W  = 2;
	localparam int SHIFT_W = 4;

	localparam logic [RATE_W-1:0] RATE_MIN = RATE_W'(46);
	localparam logic [RATE_W-1:0] RATE_MAX = RATE_W'(3000000);
	localparam logic [DIV1_W-1:0] DIV_LOW  = DIV1_W'(9);
	localparam logic [DIV1_W-1:0] DIV_HIGH = DIV1_W'(255);
	localparam logic [DIVQ_W-1:0] DIV_WRAP = DIVQ_W'(256);
	localparam logic [DIVQ_W-1:0] DIV_TINY = DIVQ_W'(2);
	localparam logic [BYTE_W-1:0] VERSION_LIMIT = 8'h27;
	localparam int unsigned SCALE = 16;
	localparam int SCALE_SH = 5;

	// log2 of the clock divider for a prescaler step and base factor
	function automatic logic [SHIFT_W-1:0] clk_shift(input logic [STEP_W-1:0] step,
			input logic fact);
		logic [SHIFT_W-1:0] s3;
		s3 = SHIFT_W'({step, 1'b0}) + SHIFT_W'(step);
		return SHIFT_W'(12) - s3 - SHIFT_W'(fact);
	endfunction

endpackage

@@ sv/ubd_div_stage.sv @@
// One registered slice of a restoring divider, STEPS quotient bits per slice.
module ubd_div_stage import ubd_pkg::*; #(
	parameter int DEN_W = DIVQ_W,
	parameter int Q_W   = DIV1_W,
	parameter int STEPS = 4
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DEN_W-1:0] src_rem,
	input  logic [Q_W-1:0]   src_quo,
	input  logic [DEN_W-1:0] src_den,
	output logic [DEN_W-1:0] rem,
	output logic [Q_W-1:0]   quo,
	output logic [DEN_W-1:0] den
);

	logic [DEN_W:0]   trial;
	logic [DEN_W-1:0] r_nx;
	logic [Q_W-1:0]   q_nx;

	always_comb begin
		r_nx  = src_rem;
		q_nx  = src_quo;
		trial = '0;
		for (int i = 0; i < STEPS; i++) begin
			trial = {r_nx, q_nx[Q_W-1]};
			q_nx  = {q_nx[Q_W-2:0], 1'b0};
			if (trial >= {1'b0, src_den}) begin
				trial   = trial - {1'b0, src_den};
				q_nx[0] = 1'b1;
			end
			r_nx = trial[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem <= r_nx;
			quo <= q_nx;
			den <= src_den;
		end
	end

endmodule

@@ sv/uart_baud_divisor_calc_top.sv @@
// Top level of the baud divisor calculator: front end, dividers, rounding and packing.
//
// Usage:
//   Input channel: baud_rate with in_valid / in_stall; a transfer happens on a
//   rising edge with in_valid high and in_stall low. Output channel: status,
//   prescaler, fast_factor, divisor_byte, register_word with out_valid /
//   out_stall, same rule. Every request gives exactly one result, in order.
//   Configuration: cfg_wr_en / cfg_wr_data write chip_version; write it only
//   while no request is in flight.
//   Throughput is one request per cycle while out_stall is low: a nine stage
//   pipeline (range check and prescaler pick, two slices of the 9 bit rate
//   divider, halving, four slices of the two parallel rounding dividers,
//   rounding and packing).
//   Each stage holds when the stage after it is full and stalled, so bubbles
//   still close up behind a stalled result and nothing is lost or repeated.
//   in_stall rises only when the whole pipe is full and the output stalls.
//   Reset clears all valid bits and chip_version; data registers are not reset.
module uart_baud_divisor_calc_top import ubd_pkg::*; #(
	parameter int unsigned REF_CLOCK_HZ = REF_CLOCK_HZ_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [BYTE_W-1:0]   cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [RATE_W-1:0]   baud_rate,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                status,
	output logic [STEP_W-1:0]   prescaler,
	output logic                fast_factor,
	output logic [BYTE_W-1:0]   divisor_byte,
	output logic [WORD_W-1:0]   register_word
);

	localparam int CLK_W   = $clog2(REF_CLOCK_HZ + 1);
	localparam int N16_W   = $clog2(SCALE * REF_CLOCK_HZ + 1);
	localparam int QST     = 4;
	localparam int QSTEP   = (N16_W + QST - 1) / QST;
	localparam int TQ      = QST * QSTEP;
	localparam int NSTG    = 9;
	localparam int CMP_W   = 32;

	localparam logic [CLK_W-1:0] REF_CLK = CLK_W'(REF_CLOCK_HZ);
	localparam logic [N16_W-1:0] REF_X16 = N16_W'(SCALE * REF_CLOCK_HZ);

	// lowest rate each prescaler step can reach with a 512 divisor
	localparam logic [RATE_W-1:0] MIN_R3 = RATE_W'(REF_CLOCK_HZ >> 11);
	localparam logic [RATE_W-1:0] MIN_R2 = RATE_W'(REF_CLOCK_HZ >> 14);
	localparam logic [RATE_W-1:0] MIN_R1 = RATE_W'(REF_CLOCK_HZ >> 17);
	localparam logic [RATE_W-1:0] MIN_R0 = RATE_W'(REF_CLOCK_HZ >> 20);

	logic [BYTE_W-1:0] chip_version_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_version_q <= '0;
		end else if (cfg_wr_en) begin
			chip_version_q <= cfg_wr_data;
		end
	end

	// ---------------- valid chain and per-stage load enables ----------------
	logic [NSTG:1]   vld;
	logic [NSTG+1:1] ld;

	always_comb begin
		ld[NSTG+1] = !out_stall;
		for (int k = NSTG; k >= 1; k--) begin
			ld[k] = !vld[k] || ld[k+1];
		end
	end

	assign in_stall = !ld[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (ld[1]) begin
				vld[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (ld[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	// ---------------- stage 1: range check and prescaler pick ----------------
	logic [RATE_W-1:0] rate_s [1:8];
	logic [STEP_W-1:0] step_s [1:8];
	logic              bad_s  [1:8];
	logic              fact_s [4:8];
	logic [DIV1_W-1:0] divp_s [4:8];
	logic [CLK_W-1:0]  n1_s1;

	logic [STEP_W-1:0] step_pick;
	logic              found;
	logic              in_range;

	always_comb begin
		in_range = (baud_rate >= RATE_MIN) && (baud_rate <= RATE_MAX);
		found    = 1'b1;
		priority if (baud_rate > MIN_R3) begin
			step_pick = 2'd3;
		end else if (baud_rate > MIN_R2) begin
			step_pick = 2'd2;
		end else if (baud_rate > MIN_R1) begin
			step_pick = 2'd1;
		end else if (baud_rate > MIN_R0) begin
			step_pick = 2'd0;
		end else begin
			step_pick = 2'd0;
			found     = 1'b0;
		end
	end

	// ---------------- stages 2..3: rate divider ----------------
	logic [RATE_W-1:0] d1_rem [1:3];
	logic [DIV1_W-1:0] d1_quo [1:3];
	logic [RATE_W-1:0] d1_den [1:3];

	// quotient is below 512 by choice of the step, so the high part starts as remainder
	assign d1_rem[1] = RATE_W'(n1_s1 >> DIV1_W);
	assign d1_quo[1] = n1_s1[DIV1_W-1:0];
	assign d1_den[1] = rate_s[1];

	ubd_div_stage #(.DEN_W(RATE_W), .Q_W(DIV1_W), .STEPS(5)) u_d1a (
		.clk(clk), .en(ld[2]),
		.src_rem(d1_rem[1]), .src_quo(d1_quo[1]), .src_den(d1_den[1]),
		.rem(d1_rem[2]), .quo(d1_quo[2]), .den(d1_den[2])
	);

	ubd_div_stage #(.DEN_W(RATE_W), .Q_W(DIV1_W), .STEPS(DIV1_W - 5)) u_d1b (
		.clk(clk), .en(ld[3]),
		.src_rem(d1_rem[2]), .src_quo(d1_quo[2]), .src_den(d1_den[2]),
		.rem(d1_rem[3]), .quo(d1_quo[3]), .den(d1_den[3])
	);

	// ---------------- stage 4: halving and rounding numerator ----------------
	logic [DIV1_W-1:0] d_raw;
	logic              halve;
	logic [DIV1_W-1:0] divp_nx;
	logic [TQ-1:0]     n16_s4;

	assign d_raw   = d1_quo[3];
	assign halve   = (d_raw < DIV_LOW) || (d_raw > DIV_HIGH);
	assign divp_nx = halve ? (d_raw >> 1) : d_raw;

	// ---------------- sideband registers ----------------
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			rate_s[1] <= baud_rate;
			step_s[1] <= step_pick;
			bad_s[1]  <= !in_range || !found;
			n1_s1     <= REF_CLK >> clk_shift(step_pick, 1'b1);
		end
		for (int k = 2; k <= 8; k++) begin
			if (ld[k]) begin
				rate_s[k] <= rate_s[k-1];
				step_s[k] <= step_s[k-1];
				if (k != 4) begin
					bad_s[k] <= bad_s[k-1];
				end
			end
		end
		if (ld[4]) begin
			// drop divisors below 2 after halving
			bad_s[4]  <= bad_s[3] || (DIVQ_W'(divp_nx) < DIV_TINY);
			fact_s[4] <= !halve;
			divp_s[4] <= divp_nx;
			n16_s4    <= TQ'(REF_X16 >> clk_shift(step_s[3], !halve));
		end
		for (int k = 5; k <= 8; k++) begin
			if (ld[k]) begin
				fact_s[k] <= fact_s[k-1];
				divp_s[k] <= divp_s[k-1];
			end
		end
	end

	// ---------------- stages 5..8: 16x quotients at div and div+1 ----------------
	logic [DIVQ_W-1:0] qa_rem [4:8];
	logic [TQ-1:0]     qa_quo [4:8];
	logic [DIVQ_W-1:0] qa_den [4:8];
	logic [DIVQ_W-1:0] qb_rem [4:8];
	logic [TQ-1:0]     qb_quo [4:8];
	logic [DIVQ_W-1:0] qb_den [4:8];

	assign qa_rem[4] = '0;
	assign qa_quo[4] = n16_s4;
	assign qa_den[4] = DIVQ_W'(divp_s[4]);
	assign qb_rem[4] = '0;
	assign qb_quo[4] = n16_s4;
	assign qb_den[4] = DIVQ_W'(divp_s[4]) + DIVQ_W'(1);

	for (genvar g = 5; g <= 8; g++) begin : g_qdiv
		ubd_div_stage #(.DEN_W(DIVQ_W), .Q_W(TQ), .STEPS(QSTEP)) u_qa (
			.clk(clk), .en(ld[g]),
			.src_rem(qa_rem[g-1]), .src_quo(qa_quo[g-1]), .src_den(qa_den[g-1]),
			.rem(qa_rem[g]), .quo(qa_quo[g]), .den(qa_den[g])
		);
		ubd_div_stage #(.DEN_W(DIVQ_W), .Q_W(TQ), .STEPS(QSTEP)) u_qb (
			.clk(clk), .en(ld[g]),
			.src_rem(qb_rem[g-1]), .src_quo(qb_quo[g-1]), .src_den(qb_den[g-1]),
			.rem(qb_rem[g]), .quo(qb_quo[g]), .den(qb_den[g])
		);
	end

	// ---------------- stage 9: round, prefer slow clock, pack ----------------
	logic [CMP_W-1:0]  q_sum;
	logic [CMP_W-1:0]  rate_x32;
	logic [DIVQ_W-1:0] div_rnd;
	logic [DIVQ_W-1:0] div_fin;
	logic              fact_fin;
	logic [BYTE_W-1:0] byte_fin;
	logic              flag;

	always_comb begin
		q_sum    = CMP_W'(qa_quo[8]) + CMP_W'(qb_quo[8]);
		rate_x32 = CMP_W'(rate_s[8]) << SCALE_SH;
		// step up when the next divisor lands at least as close
		div_rnd  = DIVQ_W'(divp_s[8]) + DIVQ_W'(q_sum >= rate_x32);
		if (fact_s[8] && !div_rnd[0]) begin
			div_fin  = div_rnd >> 1;
			fact_fin = 1'b0;
		end else begin
			div_fin  = div_rnd;
			fact_fin = fact_s[8];
		end
		byte_fin = BYTE_W'(DIV_WRAP - div_fin);
		flag     = chip_version_q > VERSION_LIMIT;
	end

	always_ff @(posedge clk) begin
		if (ld[9]) begin
			if (bad_s[8]) begin
				status        <= 1'b1;
				prescaler     <= '0;
				fast_factor   <= 1'b0;
				divisor_byte  <= '0;
				register_word <= '0;
			end else begin
				status        <= 1'b0;
				prescaler     <= step_s[8];
				fast_factor   <= fact_fin;
				divisor_byte  <= byte_fin;
				register_word <= {byte_fin, flag, 4'b0000, fact_fin, step_s[8]};
			end
		end
	end

	assign out_valid = vld[NSTG];

	// ---------------- checks ----------------
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld[1] && vld[NSTG]))
		else $error("input stalled with an empty first stage");

	a_div_span: assert property (@(posedge clk) disable iff (!arst_n)
		(vld[4] && !bad_s[4]) |-> (divp_s[4] >= DIV1_W'(2) && divp_s[4] <= DIV_HIGH))
		else $error("halved divisor out of span");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (register_word == '0 && prescaler == '0))
		else $error("rejected result carries a nonzero word");

endmodule
